@@ sv/brainfuck_instruction_executor_macros.svh @@
// ----------------------------------------------------------------------------
// brainfuck instruction executor assertion macros
// shared concurrent assertion forms, clocked on clk and disabled in rst
// ----------------------------------------------------------------------------
`ifndef BRAINFUCK_INSTRUCTION_EXECUTOR_MACROS_SVH
`define BRAINFUCK_INSTRUCTION_EXECUTOR_MACROS_SVH

// property that holds on every clock edge
`define BFE_ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// same-cycle implication
`define BFE_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define BFE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ sv/bfe_pkg.sv @@
// ----------------------------------------------------------------------------
// bfe_pkg
// opcodes, instruction characters, stop codes and controller/datapath structs
// ----------------------------------------------------------------------------
`default_nettype none

package bfe_pkg;

  // item opcodes
  localparam logic [1:0] OP_CLEAR = 2'd0;
  localparam logic [1:0] OP_LOAD  = 2'd1;
  localparam logic [1:0] OP_STEP  = 2'd2;

  // instruction characters
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_RIGHT  = 8'h3E;
  localparam logic [7:0] CH_LEFT   = 8'h3C;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RBRACK = 8'h5D;

  // stop codes
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_PROG_FULL = 3'd1;
  localparam logic [2:0] ST_STACK_OVF = 3'd2;
  localparam logic [2:0] ST_UNM_CLOSE = 3'd3;
  localparam logic [2:0] ST_UNM_OPEN  = 3'd4;

  localparam int POS_W = 10;

  // controller to datapath
  typedef struct packed {
    logic accept;
    logic zero_cell;
    logic exec;
    logic scan;
    logic pop;
    logic load_out;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic runnable;
    logic go_scan;
    logic go_pop;
    logic scan_end;
  } stat_t;

endpackage

`default_nettype wire

@@ sv/bfe_ram.sv @@
// ----------------------------------------------------------------------------
// bfe_ram
// generic single write port, single read port memory with registered read
// ----------------------------------------------------------------------------
`default_nettype none

module bfe_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 512
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ sv/bfe_ctrl.sv @@
// ----------------------------------------------------------------------------
// bfe_ctrl
// sequencer: item accept, cell clear, instruction fetch, bracket scan, loop pop, result
// ----------------------------------------------------------------------------
`default_nettype none

`include "brainfuck_instruction_executor_macros.svh"

module bfe_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire logic [1:0]    opcode,
  output logic               result_valid,
  input  wire logic          result_ready,
  input  wire bfe_pkg::stat_t stat,
  output bfe_pkg::cmd_t      cmd
);

  localparam logic [2:0] S_INIT  = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_CLR   = 3'd2;
  localparam logic [2:0] S_FETCH = 3'd3;
  localparam logic [2:0] S_SCAN  = 3'd4;
  localparam logic [2:0] S_POP   = 3'd5;
  localparam logic [2:0] S_DONE  = 3'd6;

  logic [2:0] state, state_next;
  logic       out_free;
  logic       accept;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign out_free = !result_valid || result_ready;

  always_comb begin
    cmd           = '0;
    cmd.accept    = accept;
    cmd.zero_cell = (state == S_INIT) || (state == S_CLR);
    cmd.exec      = (state == S_FETCH);
    cmd.scan      = (state == S_SCAN);
    cmd.pop       = (state == S_POP);
    cmd.load_out  = (state == S_DONE) && out_free;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_INIT: state_next = S_IDLE;
      S_IDLE: begin
        if (accept) begin
          if (opcode == bfe_pkg::OP_CLEAR) begin
            state_next = S_CLR;
          end else if (opcode == bfe_pkg::OP_STEP && stat.runnable) begin
            state_next = S_FETCH;
          end else begin
            state_next = S_DONE;
          end
        end
      end
      S_CLR: state_next = S_DONE;
      S_FETCH: begin
        if (stat.go_scan) begin
          state_next = S_SCAN;
        end else if (stat.go_pop) begin
          state_next = S_POP;
        end else begin
          state_next = S_DONE;
        end
      end
      S_SCAN: begin
        if (stat.scan_end) begin
          state_next = S_DONE;
        end
      end
      S_POP: state_next = S_DONE;
      S_DONE: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_INIT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_INIT;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  `BFE_ASSERT_IMPL(a_load_when_free, cmd.load_out, !result_valid || result_ready, "result overwritten before transaction")
  `BFE_ASSERT_NEXT(a_clear_zeroes_cell, accept && opcode == bfe_pkg::OP_CLEAR, cmd.zero_cell, "clear did not zero cell")

endmodule

`default_nettype wire

@@ sv/bfe_dpath.sv @@
// ----------------------------------------------------------------------------
// bfe_dpath
// program, data and loop stores, pointers, stop status and result register
// ----------------------------------------------------------------------------
`default_nettype none

`include "brainfuck_instruction_executor_macros.svh"

module bfe_dpath #(
  parameter int PROG_DEPTH  = 512,
  parameter int DATA_DEPTH  = 32768,
  parameter int STACK_DEPTH = 64
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire bfe_pkg::cmd_t             cmd,
  output bfe_pkg::stat_t                 stat,
  input  wire logic [1:0]                opcode,
  input  wire logic [7:0]                prog_char,
  input  wire logic [7:0]                input_char,
  output logic                           out_valid,
  output logic [7:0]                     out_char,
  output logic                           input_used,
  output logic                           halted,
  output logic [2:0]                     status,
  output logic [bfe_pkg::POS_W-1:0]      program_position
);

  localparam int PW = $clog2(PROG_DEPTH + 1);
  localparam int PA = $clog2(PROG_DEPTH);
  localparam int DA = $clog2(DATA_DEPTH);
  localparam int CW = $clog2(DATA_DEPTH + 1);
  localparam int SW = $clog2(STACK_DEPTH + 1);
  localparam int SA = $clog2(STACK_DEPTH);

  localparam logic [PW-1:0] PROG_FULL = PW'(PROG_DEPTH);
  localparam logic [DA-1:0] DATA_LAST = DA'(DATA_DEPTH - 1);
  localparam logic [CW-1:0] DATA_ALL  = CW'(DATA_DEPTH);
  localparam logic [SW-1:0] STK_FULL  = SW'(STACK_DEPTH);

  // control state
  logic [PW-1:0] len, len_next, pc, pc_next, sp, sp_next, lvl, lvl_next;
  logic [DA-1:0] ci, ci_next, hi, hi_next, lo, lo_next;
  logic [CW-1:0] cnt, cnt_next;
  logic [SW-1:0] depth, depth_next;
  logic          stopped, stopped_next;
  logic [2:0]    code, code_next;
  logic          emit, emit_next, used, used_next;
  logic [7:0]    ech, ech_next;
  logic [7:0]    ich;

  // memory ports
  logic          prog_we;
  logic [PA-1:0] prog_raddr;
  logic [7:0]    prog_rdata;
  logic          cell_we;
  logic [DA-1:0] cell_waddr;
  logic [7:0]    cell_wdata, cell_rdata;
  logic          stk_we;
  logic [PA-1:0] stk_rdata;

  logic [PW-1:0] pc_inc, sp_inc;
  logic [DA-1:0] ci_inc, ci_dec;
  logic [SW-1:0] depth_m1;
  logic          full;
  logic [PW+bfe_pkg::POS_W-1:0] pc_wide;

  assign pc_inc   = pc + PW'(1);
  assign sp_inc   = sp + PW'(1);
  assign ci_inc   = (ci == DATA_LAST) ? '0 : ci + DA'(1);
  assign ci_dec   = (ci == '0) ? DATA_LAST : ci - DA'(1);
  assign depth_m1 = depth - SW'(1);
  // every cell touched since the last clear lies in the interval lo..hi around
  // cell 0 and has been written; a cell entered at either edge is zeroed first
  assign full     = (cnt == DATA_ALL);
  assign pc_wide  = {{bfe_pkg::POS_W{1'b0}}, pc};

  assign prog_raddr = cmd.scan ? sp_inc[PA-1:0] : (cmd.exec ? pc_inc[PA-1:0] : pc[PA-1:0]);

  always_comb begin
    stat.runnable = !stopped && (pc < len);
    stat.go_scan  = (prog_rdata == bfe_pkg::CH_LBRACK) && (cell_rdata == 8'd0) && (pc_inc < len);
    stat.go_pop   = (prog_rdata == bfe_pkg::CH_RBRACK) && (depth != '0) && (cell_rdata != 8'd0);
    stat.scan_end = (prog_rdata == bfe_pkg::CH_NUL)
                 || (prog_rdata == bfe_pkg::CH_RBRACK && lvl == PW'(1))
                 || (sp_inc >= len);
  end

  always_comb begin
    len_next     = len;
    pc_next      = pc;
    sp_next      = sp;
    lvl_next     = lvl;
    ci_next      = ci;
    hi_next      = hi;
    lo_next      = lo;
    cnt_next     = cnt;
    depth_next   = depth;
    stopped_next = stopped;
    code_next    = code;
    emit_next    = emit;
    used_next    = used;
    ech_next     = ech;
    prog_we      = 1'b0;
    cell_we      = 1'b0;
    cell_waddr   = ci;
    cell_wdata   = 8'd0;
    stk_we       = 1'b0;

    if (cmd.accept) begin
      emit_next = 1'b0;
      used_next = 1'b0;
      ech_next  = 8'd0;
      unique case (opcode)
        bfe_pkg::OP_CLEAR: begin
          len_next     = '0;
          pc_next      = '0;
          ci_next      = '0;
          hi_next      = '0;
          lo_next      = '0;
          cnt_next     = CW'(1);
          depth_next   = '0;
          stopped_next = 1'b0;
          code_next    = bfe_pkg::ST_OK;
        end
        bfe_pkg::OP_LOAD: begin
          if (len < PROG_FULL) begin
            prog_we  = 1'b1;
            len_next = len + PW'(1);
          end else begin
            stopped_next = 1'b1;
            code_next    = bfe_pkg::ST_PROG_FULL;
          end
        end
        bfe_pkg::OP_STEP: begin
          if (!stopped && !(pc < len)) begin
            stopped_next = 1'b1;
            code_next    = bfe_pkg::ST_OK;
          end
        end
        default: ;
      endcase
    end else if (cmd.zero_cell) begin
      cell_we = 1'b1;
    end else if (cmd.exec) begin
      pc_next = pc_inc;
      unique case (prog_rdata)
        bfe_pkg::CH_NUL: begin
          pc_next      = pc;
          stopped_next = 1'b1;
          code_next    = bfe_pkg::ST_OK;
        end
        bfe_pkg::CH_RIGHT: begin
          ci_next = ci_inc;
          if (!full && ci == hi) begin
            cell_we    = 1'b1;
            cell_waddr = ci_inc;
            hi_next    = ci_inc;
            cnt_next   = cnt + CW'(1);
          end
        end
        bfe_pkg::CH_LEFT: begin
          ci_next = ci_dec;
          if (!full && ci == lo) begin
            cell_we    = 1'b1;
            cell_waddr = ci_dec;
            lo_next    = ci_dec;
            cnt_next   = cnt + CW'(1);
          end
        end
        bfe_pkg::CH_PLUS: begin
          cell_we    = 1'b1;
          cell_wdata = cell_rdata + 8'd1;
        end
        bfe_pkg::CH_MINUS: begin
          cell_we    = 1'b1;
          cell_wdata = cell_rdata - 8'd1;
        end
        bfe_pkg::CH_DOT: begin
          emit_next = 1'b1;
          ech_next  = cell_rdata;
        end
        bfe_pkg::CH_COMMA: begin
          cell_we    = 1'b1;
          cell_wdata = ich;
          used_next  = 1'b1;
        end
        bfe_pkg::CH_LBRACK: begin
          if (cell_rdata == 8'd0) begin
            pc_next = pc;
            if (pc_inc < len) begin
              sp_next  = pc_inc;
              lvl_next = PW'(1);
            end else begin
              stopped_next = 1'b1;
              code_next    = bfe_pkg::ST_UNM_OPEN;
            end
          end else if (depth == STK_FULL) begin
            pc_next      = pc;
            stopped_next = 1'b1;
            code_next    = bfe_pkg::ST_STACK_OVF;
          end else begin
            stk_we     = 1'b1;
            depth_next = depth + SW'(1);
          end
        end
        bfe_pkg::CH_RBRACK: begin
          if (depth == '0) begin
            pc_next      = pc;
            stopped_next = 1'b1;
            code_next    = bfe_pkg::ST_UNM_CLOSE;
          end else if (cell_rdata != 8'd0) begin
            pc_next = pc;
          end else begin
            depth_next = depth_m1;
          end
        end
        default: ;
      endcase
    end else if (cmd.scan) begin
      if (prog_rdata == bfe_pkg::CH_NUL) begin
        stopped_next = 1'b1;
        code_next    = bfe_pkg::ST_UNM_OPEN;
      end else if (prog_rdata == bfe_pkg::CH_RBRACK && lvl == PW'(1)) begin
        pc_next = sp_inc;
      end else begin
        if (prog_rdata == bfe_pkg::CH_LBRACK) begin
          lvl_next = lvl + PW'(1);
        end else if (prog_rdata == bfe_pkg::CH_RBRACK) begin
          lvl_next = lvl - PW'(1);
        end
        if (sp_inc >= len) begin
          stopped_next = 1'b1;
          code_next    = bfe_pkg::ST_UNM_OPEN;
        end else begin
          sp_next = sp_inc;
        end
      end
    end else if (cmd.pop) begin
      pc_next = PW'(stk_rdata) + PW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      len     <= '0;
      pc      <= '0;
      sp      <= '0;
      lvl     <= '0;
      ci      <= '0;
      hi      <= '0;
      lo      <= '0;
      cnt     <= CW'(1);
      depth   <= '0;
      stopped <= 1'b0;
      code    <= bfe_pkg::ST_OK;
      emit    <= 1'b0;
      used    <= 1'b0;
      ech     <= 8'd0;
    end else begin
      len     <= len_next;
      pc      <= pc_next;
      sp      <= sp_next;
      lvl     <= lvl_next;
      ci      <= ci_next;
      hi      <= hi_next;
      lo      <= lo_next;
      cnt     <= cnt_next;
      depth   <= depth_next;
      stopped <= stopped_next;
      code    <= code_next;
      emit    <= emit_next;
      used    <= used_next;
      ech     <= ech_next;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      ich <= input_char;
    end
    if (cmd.load_out) begin
      out_valid        <= emit;
      out_char         <= ech;
      input_used       <= used;
      halted           <= stopped;
      status           <= code;
      program_position <= pc_wide[bfe_pkg::POS_W-1:0];
    end
  end

  bfe_ram #(.WIDTH(8), .DEPTH(PROG_DEPTH)) u_prog_ram (
    .clk   (clk),
    .we    (prog_we),
    .waddr (len[PA-1:0]),
    .wdata (prog_char),
    .raddr (prog_raddr),
    .rdata (prog_rdata)
  );

  bfe_ram #(.WIDTH(8), .DEPTH(DATA_DEPTH)) u_cell_ram (
    .clk   (clk),
    .we    (cell_we),
    .waddr (cell_waddr),
    .wdata (cell_wdata),
    .raddr (ci),
    .rdata (cell_rdata)
  );

  bfe_ram #(.WIDTH(PA), .DEPTH(STACK_DEPTH)) u_stack_ram (
    .clk   (clk),
    .we    (stk_we),
    .waddr (depth[SA-1:0]),
    .wdata (pc[PA-1:0]),
    .raddr (depth_m1[SA-1:0]),
    .rdata (stk_rdata)
  );

  `BFE_ASSERT_ALWAYS(a_pc_within_prog, pc <= len, "instruction index beyond program length")
  `BFE_ASSERT_ALWAYS(a_touched_count, cnt != '0 && cnt <= DATA_ALL, "touched cell count out of range")
  `BFE_ASSERT_ALWAYS(a_depth_bound, depth <= STK_FULL, "loop stack depth beyond capacity")

endmodule

`default_nettype wire

@@ sv/brainfuck_instruction_executor.sv @@
// ----------------------------------------------------------------------------
// brainfuck_instruction_executor
// load, unused opcode or a step that cannot run: S_IDLE, then S_DONE, which
// registers the result once the previous one is taken, then S_IDLE again
// clear: S_IDLE, S_CLR (zeroes cell 0), S_DONE
// step that runs: S_IDLE, S_FETCH, S_DONE; a '[' scan adds S_SCAN, which walks
// the program bytes, a taken ']' adds S_POP for the stack read
// reset: synchronous; S_INIT zeroes cell 0 before in_ready
// ----------------------------------------------------------------------------
`default_nettype none

module brainfuck_instruction_executor #(
  parameter int PROG_DEPTH  = 512,
  parameter int DATA_DEPTH  = 32768,
  parameter int STACK_DEPTH = 64
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  opcode,
  input  wire logic [7:0]  prog_char,
  input  wire logic [7:0]  input_char,
  output logic             result_valid,
  input  wire logic        result_ready,
  output logic             out_valid,
  output logic [7:0]       out_char,
  output logic             input_used,
  output logic             halted,
  output logic [2:0]       status,
  output logic [9:0]       program_position
);

  bfe_pkg::cmd_t  cmd;
  bfe_pkg::stat_t stat;

  bfe_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .opcode       (opcode),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .stat         (stat),
    .cmd          (cmd)
  );

  bfe_dpath #(
    .PROG_DEPTH  (PROG_DEPTH),
    .DATA_DEPTH  (DATA_DEPTH),
    .STACK_DEPTH (STACK_DEPTH)
  ) u_dpath (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .stat             (stat),
    .opcode           (opcode),
    .prog_char        (prog_char),
    .input_char       (input_char),
    .out_valid        (out_valid),
    .out_char         (out_char),
    .input_used       (input_used),
    .halted           (halted),
    .status           (status),
    .program_position (program_position)
  );

endmodule

`default_nettype wire

@@ dv/brainfuck_instruction_executor_tb.sv @@
// ----------------------------------------------------------------------------
// brainfuck_instruction_executor_tb
// short directed scripts, then random programs through the executor; every
// accepted transaction runs on an in-bench machine and each result is compared
// field by field, in order, with a checked script row or what the machine produced
// ----------------------------------------------------------------------------
module brainfuck_instruction_executor_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PROG_DEPTH  = 512;
  localparam int DATA_DEPTH  = 32768;
  localparam int STACK_DEPTH = 64;
  localparam int ITEMS       = 1500;
  localparam int MAX_PRINTS  = 200;

  // the fourth opcode does nothing but report state
  localparam logic [1:0] OP_NONE = 2'd3;

  typedef struct packed {
    logic       emit;
    logic [7:0] ch;
    logic       used;
    logic       halt;
    logic [2:0] st;
    logic [9:0] pos;
  } bf_result_t;

  typedef struct {
    logic [1:0] op;
    logic [7:0] pch;
    logic [7:0] ich;
    bit         typed;
    bf_result_t want;
  } stim_row_t;

  logic       clk;
  logic       rst;
  logic       in_valid;
  logic       in_ready;
  logic [1:0] opcode;
  logic [7:0] prog_char;
  logic [7:0] input_char;
  logic       result_valid;
  logic       result_ready;
  logic       out_valid;
  logic [7:0] out_char;
  logic       input_used;
  logic       halted;
  logic [2:0] status;
  logic [9:0] program_position;

  brainfuck_instruction_executor uut (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .opcode           (opcode),
    .prog_char        (prog_char),
    .input_char       (input_char),
    .result_valid     (result_valid),
    .result_ready     (result_ready),
    .out_valid        (out_valid),
    .out_char         (out_char),
    .input_used       (input_used),
    .halted           (halted),
    .status           (status),
    .program_position (program_position)
  );

  // machine state mirrored by the bench
  logic [7:0]  prog_mem [PROG_DEPTH];
  int          prog_len;
  int          ip;
  logic [7:0]  tape [DATA_DEPTH];
  logic [14:0] head;
  int          loop_mem [STACK_DEPTH];
  int          nest;
  bit          mach_stopped;
  logic [2:0]  stop_code;

  bf_result_t  awaited_results [$];
  stim_row_t   script [$];
  bit          row_typed;
  bf_result_t  row_want;
  int          errors;
  int          sent;
  bit          steady;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #50ms;
    $display("TEST FAILED");
    $finish;
  end

  function automatic bf_result_t outcome(input logic emit, input logic [7:0] ch,
                                         input logic used, input logic halt,
                                         input logic [2:0] st, input logic [9:0] pos);
    bf_result_t r;
    r.emit = emit;
    r.ch   = ch;
    r.used = used;
    r.halt = halt;
    r.st   = st;
    r.pos  = pos;
    return r;
  endfunction

  function automatic void wipe_machine();
    prog_len = 0;
    ip = 0;
    head = '0;
    nest = 0;
    mach_stopped = 1'b0;
    stop_code = bfe_pkg::ST_OK;
    foreach (tape[i]) tape[i] = 8'h00;
    foreach (prog_mem[i]) prog_mem[i] = 8'h00;
    foreach (loop_mem[i]) loop_mem[i] = 0;
  endfunction

  function automatic void stop_with(input logic [2:0] code);
    mach_stopped = 1'b1;
    stop_code = code;
  endfunction

  // past the loaded program reads as end of program
  function automatic logic [7:0] byte_at(input int p);
    if (p >= prog_len) return bfe_pkg::CH_NUL;
    return prog_mem[p];
  endfunction

  function automatic void execute_instr(input logic [7:0] ich, inout bf_result_t r);
    int         pc;
    int         p;
    int         level;
    logic [7:0] instr;
    logic [7:0] b;
    pc = ip;
    instr = byte_at(pc);
    if (instr == bfe_pkg::CH_NUL) begin
      stop_with(bfe_pkg::ST_OK);
      return;
    end
    case (instr)
      bfe_pkg::CH_RIGHT: head = head + 15'd1;
      bfe_pkg::CH_LEFT:  head = head - 15'd1;
      bfe_pkg::CH_PLUS:  tape[head] = tape[head] + 8'd1;
      bfe_pkg::CH_MINUS: tape[head] = tape[head] - 8'd1;
      bfe_pkg::CH_DOT: begin
        r.emit = 1'b1;
        r.ch = tape[head];
      end
      bfe_pkg::CH_COMMA: begin
        tape[head] = ich;
        r.used = 1'b1;
      end
      bfe_pkg::CH_LBRACK: begin
        if (tape[head] == 8'h00) begin
          // skip forward to the matching close
          level = 1;
          p = pc;
          while (level != 0) begin
            p++;
            b = byte_at(p);
            if (b == bfe_pkg::CH_NUL) begin
              stop_with(bfe_pkg::ST_UNM_OPEN);
              return;
            end
            if (b == bfe_pkg::CH_LBRACK) level++;
            else if (b == bfe_pkg::CH_RBRACK) level--;
          end
          pc = p;
        end else begin
          if (nest >= STACK_DEPTH) begin
            stop_with(bfe_pkg::ST_STACK_OVF);
            return;
          end
          loop_mem[nest] = pc;
          nest++;
        end
      end
      bfe_pkg::CH_RBRACK: begin
        if (nest == 0) begin
          stop_with(bfe_pkg::ST_UNM_CLOSE);
          return;
        end
        if (tape[head] != 8'h00) pc = loop_mem[nest-1];
        else nest--;
      end
      default: ;
    endcase
    ip = pc + 1;
  endfunction

  function automatic bf_result_t interpret_item(input logic [1:0] op, input logic [7:0] pch,
                                                input logic [7:0] ich);
    bf_result_t r;
    r = '0;
    case (op)
      bfe_pkg::OP_CLEAR: wipe_machine();
      bfe_pkg::OP_LOAD: begin
        if (prog_len < PROG_DEPTH) begin
          prog_mem[prog_len] = pch;
          prog_len++;
        end else begin
          stop_with(bfe_pkg::ST_PROG_FULL);
        end
      end
      bfe_pkg::OP_STEP: if (!mach_stopped) execute_instr(ich, r);
      default: ;
    endcase
    r.halt = mach_stopped;
    r.st = stop_code;
    r.pos = ip[9:0];
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    if (errors < MAX_PRINTS)
      $display("[%0t] %s: got %0d, expected %0d", $realtime, what, got, want);
    errors++;
  endtask

  task automatic check_result(input bf_result_t got, input bf_result_t want);
    if (got.emit !== want.emit) report_mismatch("out_valid", got.emit, want.emit);
    if (got.ch !== want.ch) report_mismatch("out_char", got.ch, want.ch);
    if (got.used !== want.used) report_mismatch("input_used", got.used, want.used);
    if (got.halt !== want.halt) report_mismatch("halted", got.halt, want.halt);
    if (got.st !== want.st) report_mismatch("status", got.st, want.st);
    if (got.pos !== want.pos) report_mismatch("program_position", got.pos, want.pos);
  endtask

  // results are checked before the transaction of the same edge is interpreted
  always @(posedge clk) begin : scoreboard
    bf_result_t got;
    bf_result_t model;
    if (!rst) begin
      if (result_valid && result_ready) begin
        got = {out_valid, out_char, input_used, halted, status, program_position};
        if (awaited_results.size() == 0)
          report_mismatch("result with nothing pending, position", got.pos, -1);
        else
          check_result(got, awaited_results.pop_front());
      end
      if (in_valid && in_ready) begin
        model = interpret_item(opcode, prog_char, input_char);
        awaited_results.push_back(row_typed ? row_want : model);
      end
    end
  end

  initial begin
    result_ready = 1'b0;
    @(negedge clk);
    forever begin
      result_ready = 1'b1;
      if (steady) begin
        @(negedge clk);
      end else begin
        repeat (($urandom_range(0, 4) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 8))
          @(negedge clk);
        if (!steady && $urandom_range(0, 2) != 0) begin
          result_ready = 1'b0;
          repeat ($urandom_range(1, 7)) @(negedge clk);
        end
      end
    end
  end

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic offer(input logic [1:0] op, input logic [7:0] pch, input logic [7:0] ich,
                       input bit typed, input bf_result_t want);
    int gap;
    gap = (!steady && $urandom_range(0, 3) == 0) ? $urandom_range(1, 7) : 0;
    if (gap != 0) begin
      in_valid = 1'b0;
      opcode = 2'($urandom);
      prog_char = 8'($urandom);
      input_char = 8'($urandom);
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    opcode = op;
    prog_char = pch;
    input_char = ich;
    row_typed = typed;
    row_want = want;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent++;
    steady = (sent >= ITEMS - 150);
    @(negedge clk);
  endtask

  task automatic send(input logic [1:0] op, input logic [7:0] pch, input logic [7:0] ich);
    offer(op, pch, ich, 1'b0, '0);
  endtask

  task automatic row(input logic [1:0] op, input logic [7:0] pch, input logic [7:0] ich);
    script.push_back('{op, pch, ich, 1'b0, '0});
  endtask

  task automatic row_chk(input logic [1:0] op, input logic [7:0] pch, input logic [7:0] ich,
                         input bf_result_t want);
    script.push_back('{op, pch, ich, 1'b1, want});
  endtask

  task automatic wait_for_drain();
    in_valid = 1'b0;
    do @(negedge clk); while (awaited_results.size() != 0);
  endtask

  // tidy programs keep their brackets balanced, the rest is noise
  function automatic logic [7:0] pick_char(input bit tidy, inout int open_brackets);
    logic [7:0] c;
    case ($urandom_range(0, 11))
      0, 1:    c = bfe_pkg::CH_PLUS;
      2:       c = bfe_pkg::CH_MINUS;
      3:       c = bfe_pkg::CH_RIGHT;
      4:       c = bfe_pkg::CH_LEFT;
      5:       c = bfe_pkg::CH_DOT;
      6:       c = bfe_pkg::CH_COMMA;
      7, 8:    c = bfe_pkg::CH_LBRACK;
      9:       c = bfe_pkg::CH_RBRACK;
      10:      c = tidy ? bfe_pkg::CH_MINUS : 8'($urandom_range(0, 255));
      default: c = tidy ? 8'($urandom_range(8'h61, 8'h7A)) : bfe_pkg::CH_NUL;
    endcase
    if (tidy) begin
      if (c == bfe_pkg::CH_LBRACK) begin
        open_brackets++;
      end else if (c == bfe_pkg::CH_RBRACK) begin
        if (open_brackets == 0) c = bfe_pkg::CH_PLUS;
        else open_brackets--;
      end
    end
    return c;
  endfunction

  task automatic run_program();
    int  len;
    int  open_brackets;
    int  steps;
    int  extra;
    bit  tidy;
    tidy = ($urandom_range(0, 9) < 7);
    // now and then keep the old machine so loads append to a used program
    if ($urandom_range(0, 9) != 0 || prog_len > 440)
      send(bfe_pkg::OP_CLEAR, 8'($urandom), 8'($urandom));
    len = $urandom_range(2, 40);
    open_brackets = 0;
    repeat (len) send(bfe_pkg::OP_LOAD, pick_char(tidy, open_brackets), 8'($urandom));
    while (open_brackets > 0) begin
      send(bfe_pkg::OP_LOAD, bfe_pkg::CH_RBRACK, 8'($urandom));
      open_brackets--;
    end
    steps = $urandom_range(10, 90);
    extra = $urandom_range(0, 2);
    for (int i = 0; i < steps; i++) begin
      if (mach_stopped) begin
        if (extra == 0) break;
        extra--;
      end
      case ($urandom_range(0, 49))
        0:       send(OP_NONE, 8'($urandom), 8'($urandom));
        1, 2:    send(bfe_pkg::OP_LOAD, pick_char(tidy, open_brackets), 8'($urandom));
        default: send(bfe_pkg::OP_STEP, 8'($urandom), 8'($urandom));
      endcase
    end
  endtask

  task automatic fill_store_phase();
    int junk;
    junk = 0;
    send(bfe_pkg::OP_CLEAR, 8'($urandom), 8'($urandom));
    repeat (PROG_DEPTH)
      send(bfe_pkg::OP_LOAD,
           $urandom_range(0, 1) ? pick_char(1'b0, junk) : 8'($urandom),
           8'($urandom));
    repeat ($urandom_range(5, 25)) send(bfe_pkg::OP_STEP, 8'($urandom), 8'($urandom));
    // program store is full from here on
    repeat (3) send(bfe_pkg::OP_LOAD, 8'($urandom), 8'($urandom));
    repeat (2) send(bfe_pkg::OP_STEP, 8'($urandom), 8'($urandom));
  endtask

  task automatic nest_phase();
    send(bfe_pkg::OP_CLEAR, 8'($urandom), 8'($urandom));
    send(bfe_pkg::OP_LOAD, bfe_pkg::CH_PLUS, 8'($urandom));
    repeat (STACK_DEPTH + 2) send(bfe_pkg::OP_LOAD, bfe_pkg::CH_LBRACK, 8'($urandom));
    repeat (STACK_DEPTH + 3) send(bfe_pkg::OP_STEP, 8'($urandom), 8'($urandom));
  endtask

  initial begin : stimulus
    int phase;
    rst = 1'b1;
    in_valid = 1'b0;
    opcode = bfe_pkg::OP_CLEAR;
    prog_char = 8'h00;
    input_char = 8'h00;
    row_typed = 1'b0;
    row_want = '0;
    errors = 0;
    sent = 0;
    steady = 1'b0;
    wipe_machine();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // empty program, clear, idle opcode
    row_chk(bfe_pkg::OP_STEP, 8'h00, 8'h00, outcome(0, 8'h00, 0, 1, bfe_pkg::ST_OK, 10'd0));
    row_chk(bfe_pkg::OP_CLEAR, 8'hFF, 8'hFF, outcome(0, 8'h00, 0, 0, bfe_pkg::ST_OK, 10'd0));
    row_chk(OP_NONE, 8'hFF, 8'hFF, outcome(0, 8'h00, 0, 0, bfe_pkg::ST_OK, 10'd0));
    // input, output, pointer wrap below zero, cell wrap, unmatched close
    row(bfe_pkg::OP_LOAD, bfe_pkg::CH_COMMA, 8'h00);
    row(bfe_pkg::OP_LOAD, bfe_pkg::CH_DOT, 8'h00);
    row(bfe_pkg::OP_LOAD, bfe_pkg::CH_LEFT, 8'h00);
    row(bfe_pkg::OP_LOAD, bfe_pkg::CH_MINUS, 8'h00);
    row(bfe_pkg::OP_LOAD, bfe_pkg::CH_DOT, 8'h00);
    row(bfe_pkg::OP_LOAD, bfe_pkg::CH_RBRACK, 8'h00);
    row_chk(bfe_pkg::OP_STEP, 8'h00, 8'hFF, outcome(0, 8'h00, 1, 0, bfe_pkg::ST_OK, 10'd1));
    row_chk(bfe_pkg::OP_STEP, 8'h00, 8'h00, outcome(1, 8'hFF, 0, 0, bfe_pkg::ST_OK, 10'd2));
    row(bfe_pkg::OP_STEP, 8'h00, 8'h00);
    row(bfe_pkg::OP_STEP, 8'h00, 8'h00);
    row_chk(bfe_pkg::OP_STEP, 8'h00, 8'h00, outcome(1, 8'hFF, 0, 0, bfe_pkg::ST_OK, 10'd5));
    row_chk(bfe_pkg::OP_STEP, 8'h00, 8'h00,
            outcome(0, 8'h00, 0, 1, bfe_pkg::ST_UNM_CLOSE, 10'd5));
    row_chk(bfe_pkg::OP_STEP, 8'hFF, 8'hFF,
            outcome(0, 8'h00, 0, 1, bfe_pkg::ST_UNM_CLOSE, 10'd5));
    row_chk(bfe_pkg::OP_LOAD, bfe_pkg::CH_PLUS, 8'h00,
            outcome(0, 8'h00, 0, 1, bfe_pkg::ST_UNM_CLOSE, 10'd5));
    // forward scan that runs off the end
    row(bfe_pkg::OP_CLEAR, 8'h00, 8'h00);
    row(bfe_pkg::OP_LOAD, bfe_pkg::CH_LBRACK, 8'h00);
    row(bfe_pkg::OP_LOAD, bfe_pkg::CH_PLUS, 8'h00);
    row_chk(bfe_pkg::OP_STEP, 8'h00, 8'h00,
            outcome(0, 8'h00, 0, 1, bfe_pkg::ST_UNM_OPEN, 10'd0));
    // zero byte ends the program
    row(bfe_pkg::OP_CLEAR, 8'h00, 8'h00);
    row(bfe_pkg::OP_LOAD, bfe_pkg::CH_NUL, 8'h00);
    row(bfe_pkg::OP_LOAD, 8'hFF, 8'h00);
    row_chk(bfe_pkg::OP_STEP, 8'h00, 8'h00, outcome(0, 8'h00, 0, 1, bfe_pkg::ST_OK, 10'd0));

    foreach (script[i])
      offer(script[i].op, script[i].pch, script[i].ich, script[i].typed, script[i].want);
    wait_for_drain();

    phase = 0;
    while (sent < ITEMS) begin
      if (phase == 2) fill_store_phase();
      else if (phase == 5) nest_phase();
      else run_program();
      if ($urandom_range(0, 5) == 0) wait_for_drain();
      phase++;
    end

    in_valid = 1'b0;
    while (awaited_results.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
